FILE: design/afr_pkg.sv
// Shared types and codes for the addressed frame receiver.
`default_nettype none

package afr_pkg;

   // Frame phases, one-hot
   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_ADDR_LO = 5'b00010,
      PH_ADDR_HI = 5'b00100,
      PH_LEN     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_CONNECT = 2'd1;
   localparam logic [1:0] KIND_POLL    = 2'd2;

   localparam logic [7:0]  HDR_FIRST     = 8'h00;
   localparam logic [7:0]  HDR_SECOND    = 8'hFF;
   localparam logic [15:0] DEVICE_ID_RST = 16'hFFFF;

   typedef struct packed {
      phase_type   phase;
      logic        prev_zero;
      logic [7:0]  addr_low;
      logic        addressed;
      logic [7:0]  bytes_left;
      logic        first_pending;
      logic        connected;
   } frame_state_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic        first;
      logic        last;
      logic        connected;
   } frame_result_type;

endpackage

`default_nettype wire

FILE: design/afr_decode.sv
// Per-byte frame decoder: next state and result for one received byte.
`default_nettype none

module afr_decode (
   input  afr_pkg::frame_state_type  cur_state,
   input  logic [7:0]                rx_byte,
   input  logic [15:0]               device_id,
   output afr_pkg::frame_state_type  nxt_state,
   output afr_pkg::frame_result_type result
);

   logic last_byte;

   assign last_byte = (cur_state.bytes_left <= 8'd1);

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      unique case (cur_state.phase)
         afr_pkg::PH_ADDR_LO: begin
            nxt_state.addr_low = rx_byte;
            nxt_state.phase    = afr_pkg::PH_ADDR_HI;
         end
         afr_pkg::PH_ADDR_HI: begin
            nxt_state.addressed = ({rx_byte, cur_state.addr_low} == device_id);
            nxt_state.phase     = afr_pkg::PH_LEN;
         end
         afr_pkg::PH_LEN: begin
            if (rx_byte != 8'd0) begin
               nxt_state.bytes_left    = rx_byte;
               nxt_state.first_pending = 1'b1;
               nxt_state.phase         = afr_pkg::PH_PAYLOAD;
            end else begin
               nxt_state.phase = afr_pkg::PH_HUNT;
               if (cur_state.addressed) begin
                  result.valid = 1'b1;
                  result.last  = 1'b1;
                  if (!cur_state.connected) begin
                     nxt_state.connected = 1'b1;
                     result.kind         = afr_pkg::KIND_CONNECT;
                  end else begin
                     result.kind = afr_pkg::KIND_POLL;
                  end
               end
            end
         end
         afr_pkg::PH_PAYLOAD: begin
            nxt_state.first_pending = 1'b0;
            nxt_state.bytes_left    = last_byte ? 8'd0 : cur_state.bytes_left - 8'd1;
            if (last_byte) begin
               nxt_state.phase = afr_pkg::PH_HUNT;
            end
            result.valid        = cur_state.addressed;
            result.kind         = afr_pkg::KIND_PAYLOAD;
            result.payload_byte = rx_byte;
            result.first        = cur_state.first_pending;
            result.last         = last_byte;
         end
         default: begin
            nxt_state.phase = afr_pkg::PH_HUNT;
            if (cur_state.prev_zero && (rx_byte == afr_pkg::HDR_SECOND)) begin
               nxt_state.phase     = afr_pkg::PH_ADDR_LO;
               nxt_state.addressed = 1'b0;
            end
            nxt_state.prev_zero = (rx_byte == afr_pkg::HDR_FIRST);
         end
      endcase
      result.connected = nxt_state.connected;
   end

endmodule

`default_nettype wire

FILE: design/addressed_frame_receiver_top.sv
// Top level of the addressed frame receiver: input register, decoder, result register.
`default_nettype none

// A request is taken into the input register, decoded, and its result (if any) loaded into the result register.
// Throughput: one request per cycle; the decoder runs once per byte between the
//   input register and the result register, and the input stalls only while a
//   held result is stalled downstream.
// Reset (synchronous, active high): hunting for a header, not connected,
//   device id 0xFFFF, both registers empty.
module addressed_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_first_of_frame,
   output logic        rsp_last_of_frame,
   output logic        rsp_link_connected,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_device_id
);

   // Device id register
   logic [15:0] device_id_ff;
   logic [15:0] device_id_in;

   // Input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [7:0]  in_byte_in;

   // Frame state
   afr_pkg::frame_state_type  state_ff;
   afr_pkg::frame_state_type  state_in;
   afr_pkg::frame_state_type  state_nxt;
   afr_pkg::frame_result_type result;

   // Result register
   logic        out_valid_ff;
   logic        out_valid_in;
   afr_pkg::frame_result_type out_ff;
   afr_pkg::frame_result_type out_in;

   logic out_free;
   logic fire;

   // The result slot is free when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // Decode the held request only when its result has somewhere to go
   assign fire      = in_valid_ff && out_free;
   // Hold the request register while its byte cannot be decoded
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   afr_decode u_decode (
      .cur_state (state_ff),
      .rx_byte   (in_byte_ff),
      .device_id (device_id_ff),
      .nxt_state (state_nxt),
      .result    (result)
   );

   always_comb begin
      device_id_in = device_id_ff;
      if (csr_valid && csr_ready) begin
         device_id_in = csr_device_id;
      end

      // Take a new request whenever the register is not held
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end

      // Advance the frame state only on a decoded byte
      state_in = fire ? state_nxt : state_ff;

      // Load a fresh result, drop a taken one, otherwise hold
      out_in = out_ff;
      if (fire && result.valid) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= afr_pkg::DEVICE_ID_RST;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase:         afr_pkg::PH_HUNT,
                           prev_zero:     1'b0,
                           addr_low:      8'd0,
                           addressed:     1'b0,
                           bytes_left:    8'd0,
                           first_pending: 1'b0,
                           connected:     1'b0};
      end else begin
         device_id_ff <= device_id_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_first_of_frame = out_ff.first;
   assign rsp_last_of_frame  = out_ff.last;
   assign rsp_link_connected = out_ff.connected;

   // Request results are always single-item frames with no payload
   a_request_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != afr_pkg::KIND_PAYLOAD)) |->
         (rsp_last_of_frame && !rsp_first_of_frame && (rsp_payload_byte == 8'd0)))
      else $error("request result with payload marks");

   // A connect or poll result always reports the link as connected
   a_request_connected : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != afr_pkg::KIND_PAYLOAD)) |-> rsp_link_connected)
      else $error("request result without connected flag");

   // Once connected, the link stays connected until reset
   a_connected_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff.connected |=> state_ff.connected)
      else $error("connected flag dropped");

   // A byte is decoded only when the result slot can take it
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> $stable(out_ff))
      else $error("held result overwritten");

endmodule

`default_nettype wire
